// ===== rtl/timer_priority_queue_defines.svh =====
// Assertion macros for the timer priority queue.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TIMER_PRIORITY_QUEUE_DEFINES_SVH
`define TIMER_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");
`define TPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");
`else
`define TPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tpq_pkg.sv =====
// Package for the timer priority queue: sizes, request and result codes,
// and the structs passed between sequencer, slot store and adder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_W  = 2;
    localparam int TIME_W = 32;
    localparam int ID_W   = 8;
    localparam int TMO_W  = 24;
    localparam int KIND_W = 3;
    localparam int WAIT_W = 31;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAIT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd6;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic              add;
        logic              cancel;
        logic              remove;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  rank;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   owner;
        logic              notify;
    } t_store_cmd;

    typedef struct packed {
        logic              used;
        logic              cancelled;
        logic              notify;
        logic [IDX_W-1:0]  rank;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   owner;
    } t_slot_view;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              carry;
        logic              zero;
    } t_alu_res;

endpackage
`default_nettype wire

// ===== rtl/tpq_req_if.sv =====
// Request channel of the timer priority queue: valid/ready plus request fields.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tpq_req_if import tpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   request_id;
    logic [TMO_W-1:0]  timeout_ms;
    logic              notify;

    modport source (output valid, req_type, now_ms, request_id, timeout_ms, notify,
                    input ready);
    modport sink   (input valid, req_type, now_ms, request_id, timeout_ms, notify,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/tpq_res_if.sv =====
// Result channel of the timer priority queue: valid/ready plus result fields.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tpq_res_if import tpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   owner_id;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;

    modport source (output valid, result_kind, owner_id, wait_ms, last, input ready);
    modport sink   (input valid, result_kind, owner_id, wait_ms, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/timer_priority_queue.sv =====
// Timer queue ordered by deadline with lazy cancellation. Every request takes at
// least one scan of all QUEUE_DEPTH slots, one slot a cycle through a single shared
// 32-bit adder, then a decide state and an emit state that loads the result
// register. Each cancelled entry purged from the head adds another scan and
// decide; a sweep rescans after each entry removed (after emitting each reported
// expiry) and closes with a done item. The slot read port and the adder set the
// scan pace. A new request is taken once the last result is in the output
// register, and stalls on the result channel hold the sequencer in its emit state.
// Depends on tpq_pkg, tpq_req_if, tpq_res_if, tpq_alu, tpq_store and tpq_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module timer_priority_queue import tpq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpq_req_if.sink   i_req,
    tpq_res_if.source o_res
);
    t_store_cmd        cmd;
    t_slot_view        view;
    t_alu_res          alu_res;
    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  count;
    logic              alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;

    tpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_res    (o_res),
        .i_view   (view),
        .i_count  (count),
        .i_alu    (alu_res),
        .o_cmd    (cmd),
        .o_rd_idx (rd_idx),
        .o_alu_op (alu_op),
        .o_alu_a  (alu_a),
        .o_alu_b  (alu_b)
    );

    tpq_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_idx (rd_idx),
        .o_view   (view),
        .o_count  (count)
    );

    tpq_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );
endmodule
`default_nettype wire

// ===== rtl/tpq_alu.sv =====
// Shared 32-bit add/subtract unit with carry-out (borrow on subtract) and zero flag.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpq_alu import tpq_pkg::*; (
    input  wire logic              i_op,
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    output t_alu_res               o_res
);
    logic [TIME_W:0] sum;

    always_comb begin
        if (i_op == ALU_SUB) begin
            sum = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            sum = {1'b0, i_a} + {1'b0, i_b};
        end
        o_res.res   = sum[TIME_W-1:0];
        o_res.carry = sum[TIME_W];
        o_res.zero  = (sum[TIME_W-1:0] == '0);
    end
endmodule
`default_nettype wire

// ===== rtl/tpq_store.sv =====
// Slot store: deadline and owner per slot, live/cancel/notify flags, insertion
// rank and fill count. Depends on tpq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_priority_queue_defines.svh"
module tpq_store import tpq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_store_cmd       i_cmd,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output t_slot_view            o_view,
    output logic [CNT_W-1:0]      o_count
);
    logic [TIME_W-1:0]      r_deadline [QUEUE_DEPTH];
    logic [ID_W-1:0]        r_owner    [QUEUE_DEPTH];
    logic [IDX_W-1:0]       r_rank     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_used;
    logic [QUEUE_DEPTH-1:0] r_cancelled;
    logic [QUEUE_DEPTH-1:0] r_notify;
    logic [CNT_W-1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_cancelled <= '0;
            r_notify    <= '0;
            r_count     <= '0;
        end else if (i_cmd.add) begin
            r_used[i_cmd.idx]      <= 1'b1;
            r_cancelled[i_cmd.idx] <= 1'b0;
            r_notify[i_cmd.idx]    <= i_cmd.notify;
            r_count                <= r_count + 1'b1;
        end else if (i_cmd.cancel) begin
            r_cancelled[i_cmd.idx] <= 1'b1;
        end else if (i_cmd.remove) begin
            r_used[i_cmd.idx]      <= 1'b0;
            r_cancelled[i_cmd.idx] <= 1'b0;
            r_notify[i_cmd.idx]    <= 1'b0;
            r_count                <= r_count - 1'b1;
        end
    end

    // payload and ranks: only read for live slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_deadline[i_cmd.idx] <= i_cmd.deadline;
            r_owner[i_cmd.idx]    <= i_cmd.owner;
            r_rank[i_cmd.idx]     <= r_count[IDX_W-1:0];
        end
        if (i_cmd.remove) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_used[i] && (r_rank[i] > i_cmd.rank)) begin
                    r_rank[i] <= r_rank[i] - 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_view.used      = r_used[i_rd_idx];
        o_view.cancelled = r_cancelled[i_rd_idx];
        o_view.notify    = r_notify[i_rd_idx];
        o_view.rank      = r_rank[i_rd_idx];
        o_view.deadline  = r_deadline[i_rd_idx];
        o_view.owner     = r_owner[i_rd_idx];
    end

    assign o_count = r_count;

    `TPQ_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, r_count == CNT_W'($countones(r_used)))
    `TPQ_ASSERT_IMP(a_add_free, i_clk, i_rst_n, i_cmd.add, !r_used[i_cmd.idx] && (r_count < CNT_W'(QUEUE_DEPTH)))
    `TPQ_ASSERT_IMP(a_remove_live, i_clk, i_rst_n, i_cmd.remove, r_used[i_cmd.idx] && (r_rank[i_cmd.idx] == i_cmd.rank))
endmodule
`default_nettype wire

// ===== rtl/tpq_ctrl.sv =====
// Sequencer: scans the slots one a cycle through the shared adder, decides per
// request, drives the slot store and the result register. Depends on tpq_pkg,
// the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_priority_queue_defines.svh"
module tpq_ctrl import tpq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    tpq_req_if.sink               i_req,
    tpq_res_if.source             o_res,
    input  wire t_slot_view       i_view,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_alu_res         i_alu,
    output t_store_cmd            o_cmd,
    output logic [IDX_W-1:0]      o_rd_idx,
    output logic                  o_alu_op,
    output logic [TIME_W-1:0]     o_alu_a,
    output logic [TIME_W-1:0]     o_alu_b
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [IDX_W-1:0]  r_best_rank, n_best_rank;
    logic [TIME_W-1:0] r_best_dl, n_best_dl;

    logic [REQ_W-1:0]  r_req, n_req;
    logic [TIME_W-1:0] r_now, n_now;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TMO_W-1:0]  r_tmo, n_tmo;
    logic              r_ntf, n_ntf;

    logic [KIND_W-1:0] r_pend_kind, n_pend_kind;
    logic [ID_W-1:0]   r_pend_owner, n_pend_owner;
    logic [WAIT_W-1:0] r_pend_wait, n_pend_wait;
    logic              r_pend_last, n_pend_last;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_owner, n_out_owner;
    logic [WAIT_W-1:0] r_out_wait, n_out_wait;
    logic              r_out_last, n_out_last;

    logic take;
    logic due;

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.owner_id    = r_out_owner;
    assign o_res.wait_ms     = r_out_wait;
    assign o_res.last        = r_out_last;

    assign due = i_alu.carry | i_alu.zero;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_rank  = r_best_rank;
        n_best_dl    = r_best_dl;
        n_req        = r_req;
        n_now        = r_now;
        n_id         = r_id;
        n_tmo        = r_tmo;
        n_ntf        = r_ntf;
        n_pend_kind  = r_pend_kind;
        n_pend_owner = r_pend_owner;
        n_pend_wait  = r_pend_wait;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_owner  = r_out_owner;
        n_out_wait   = r_out_wait;
        n_out_last   = r_out_last;
        o_cmd        = '0;
        o_cmd.idx    = r_best_idx;
        o_cmd.rank   = r_best_rank;
        o_cmd.owner  = r_id;
        o_cmd.notify = r_ntf;
        o_rd_idx     = r_best_idx;
        o_alu_op     = ALU_SUB;
        o_alu_a      = i_view.deadline;
        o_alu_b      = r_now;
        take         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.req_type;
                    n_now   = i_req.now_ms;
                    n_id    = i_req.request_id;
                    n_tmo   = i_req.timeout_ms;
                    n_ntf   = i_req.notify;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_rd_idx = r_idx;
                o_alu_b  = r_best_dl;
                case (r_req)
                    REQ_ADD: begin
                        take = !i_view.used && !r_found;
                    end
                    REQ_CANCEL: begin
                        take = i_view.used && !i_view.cancelled && (i_view.owner == r_id)
                               && (!r_found || (i_view.rank > r_best_rank));
                    end
                    default: begin
                        take = i_view.used && (!r_found || i_alu.carry
                               || (i_alu.zero && (i_view.rank < r_best_rank)));
                    end
                endcase
                if (take) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_idx;
                    n_best_rank = i_view.rank;
                    n_best_dl   = i_view.deadline;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DECIDE: begin
                n_pend_owner = r_id;
                n_pend_wait  = '0;
                n_pend_last  = 1'b1;
                n_state      = ST_EMIT;
                case (r_req)
                    REQ_ADD: begin
                        o_alu_op = ALU_ADD;
                        o_alu_a  = r_now;
                        o_alu_b  = TIME_W'(r_tmo);
                        if (!r_found || (i_count >= CNT_W'(QUEUE_DEPTH))) begin
                            n_pend_kind = KIND_FULL;
                        end else begin
                            o_cmd.add      = 1'b1;
                            o_cmd.deadline = i_alu.carry ? '1 : i_alu.res;
                            n_pend_kind    = KIND_ADDED;
                        end
                    end
                    REQ_CANCEL: begin
                        o_cmd.cancel = r_found;
                        n_pend_kind  = KIND_CANCELLED;
                    end
                    REQ_QUERY: begin
                        if (!r_found) begin
                            n_pend_kind  = KIND_EMPTY;
                            n_pend_owner = '0;
                        end else if (i_view.cancelled) begin
                            o_cmd.remove = 1'b1;
                            n_idx        = '0;
                            n_found      = 1'b0;
                            n_state      = ST_SCAN;
                        end else begin
                            n_pend_kind  = KIND_WAIT;
                            n_pend_owner = i_view.owner;
                            if (due) begin
                                n_pend_wait = '0;
                            end else if (i_alu.res[TIME_W-1]) begin
                                n_pend_wait = '1;
                            end else begin
                                n_pend_wait = i_alu.res[WAIT_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_pend_kind  = KIND_DONE;
                        n_pend_owner = '0;
                        if (r_found && (i_view.cancelled || due)) begin
                            o_cmd.remove = 1'b1;
                            n_idx        = '0;
                            n_found      = 1'b0;
                            if (!i_view.cancelled && i_view.notify) begin
                                n_pend_kind  = KIND_EXPIRED;
                                n_pend_owner = i_view.owner;
                                n_pend_last  = 1'b0;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                    end
                endcase
            end
            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_pend_kind;
                    n_out_owner = r_pend_owner;
                    n_out_wait  = r_pend_wait;
                    n_out_last  = r_pend_last;
                    if (r_pend_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx   <= n_best_idx;
        r_best_rank  <= n_best_rank;
        r_best_dl    <= n_best_dl;
        r_req        <= n_req;
        r_now        <= n_now;
        r_id         <= n_id;
        r_tmo        <= n_tmo;
        r_ntf        <= n_ntf;
        r_pend_kind  <= n_pend_kind;
        r_pend_owner <= n_pend_owner;
        r_pend_wait  <= n_pend_wait;
        r_pend_last  <= n_pend_last;
        r_out_kind   <= n_out_kind;
        r_out_owner  <= n_out_owner;
        r_out_wait   <= n_out_wait;
        r_out_last   <= n_out_last;
    end

    `TPQ_ASSERT_NXT(a_scan_steps, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_idx != IDX_LAST), (r_state == ST_SCAN) && (r_idx == $past(r_idx) + 1'b1))
    `TPQ_ASSERT_IMP(a_cancel_target, i_clk, i_rst_n, (r_state == ST_DECIDE) && (r_req == REQ_CANCEL) && r_found, i_view.used && !i_view.cancelled && (i_view.owner == r_id))
    `TPQ_ASSERT_IMP(a_expired_not_last, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_EXPIRED), !r_out_last)
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for timer_priority_queue: directed and random timer requests,
// a shadow deadline queue predicting every result, random stalls on both channels.
// Depends on tpq_pkg, tpq_req_if, tpq_res_if and the timer_priority_queue RTL.
`timescale 1ns / 1ps
module tb;
    import tpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;
    localparam int IDLE_PCT    = 38;
    localparam int RANDOM_REQS = 85;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   id;
        logic [TMO_W-1:0]  tmo;
        logic              ntf;
        bit                drain;
    } t_timer_req;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   owner;
        logic [WAIT_W-1:0] wait_ms;
        logic              last;
    } t_timer_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tpq_req_if req_ch ();
    tpq_res_if res_ch ();

    timer_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the slot store
    logic [TIME_W-1:0] sl_deadline [QUEUE_DEPTH];
    logic [ID_W-1:0]   sl_owner    [QUEUE_DEPTH];
    bit                sl_cancel   [QUEUE_DEPTH];
    bit                sl_notify   [QUEUE_DEPTH];
    bit                sl_used     [QUEUE_DEPTH];
    int                sl_rank     [QUEUE_DEPTH];
    int                sl_count = 0;

    t_timer_req request_backlog [$];
    t_timer_res timer_results_due [$];

    int n_cycles  = 0;
    int n_taken   = 0;
    int n_results = 0;
    int n_expiry  = 0;
    int n_full    = 0;
    int n_err     = 0;
    bit drv_busy  = 1'b0;
    bit req_taken = 1'b0;
    bit no_idle;
    t_timer_req drv_item;
    t_timer_res got_res;

    function automatic void post_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] owner,
                                        logic [WAIT_W-1:0] wait_ms, logic last);
        t_timer_res r;
        r.kind    = kind;
        r.owner   = owner;
        r.wait_ms = wait_ms;
        r.last    = last;
        timer_results_due.push_back(r);
        if (kind == KIND_EXPIRED) n_expiry++;
        if (kind == KIND_FULL) n_full++;
    endfunction

    // earliest entry: deadline, then insertion rank
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (sl_used[i] && (best < 0 || sl_deadline[i] < sl_deadline[best] ||
                    (sl_deadline[i] == sl_deadline[best] && sl_rank[i] < sl_rank[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic void drop_slot(int s);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (sl_used[i] && sl_rank[i] > sl_rank[s]) sl_rank[i]--;
        sl_used[s]   = 1'b0;
        sl_cancel[s] = 1'b0;
        sl_notify[s] = 1'b0;
        if (sl_count > 0) sl_count--;
    endfunction

    function automatic int live_head();
        int h;
        h = earliest_slot();
        while (h >= 0 && sl_cancel[h]) begin
            drop_slot(h);
            h = earliest_slot();
        end
        return h;
    endfunction

    function automatic void service_request(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                                            logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo,
                                            logic ntf);
        int slot;
        int best;
        int h;
        int n;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] gap;
        slot = -1;
        best = -1;
        n    = 0;
        case (req)
            REQ_ADD: begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (!sl_used[i] && slot < 0) slot = i;
                if (slot < 0 || sl_count >= QUEUE_DEPTH) begin
                    post_result(KIND_FULL, id, '0, 1'b1);
                end else begin
                    sum = {1'b0, now} + (TIME_W + 1)'(tmo);
                    sl_deadline[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    sl_owner[slot]    = id;
                    sl_cancel[slot]   = 1'b0;
                    sl_notify[slot]   = ntf;
                    sl_used[slot]     = 1'b1;
                    sl_rank[slot]     = sl_count;
                    sl_count++;
                    post_result(KIND_ADDED, id, '0, 1'b1);
                end
            end
            REQ_CANCEL: begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (sl_used[i] && !sl_cancel[i] && sl_owner[i] == id &&
                            (best < 0 || sl_rank[i] > sl_rank[best]))
                        best = i;
                if (best >= 0) sl_cancel[best] = 1'b1;
                post_result(KIND_CANCELLED, id, '0, 1'b1);
            end
            REQ_QUERY: begin
                h = live_head();
                if (h < 0) begin
                    post_result(KIND_EMPTY, '0, '0, 1'b1);
                end else begin
                    gap = (sl_deadline[h] > now) ? sl_deadline[h] - now : '0;
                    post_result(KIND_WAIT, sl_owner[h], gap[TIME_W-1] ? '1 : gap[WAIT_W-1:0],
                                1'b1);
                end
            end
            default: begin
                h = live_head();
                while (h >= 0 && sl_deadline[h] <= now) begin
                    if (sl_notify[h] && n < QUEUE_DEPTH) begin
                        post_result(KIND_EXPIRED, sl_owner[h], '0, 1'b0);
                        n++;
                    end
                    drop_slot(h);
                    h = live_head();
                end
                post_result(KIND_DONE, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void plan_request(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                                         logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo,
                                         logic ntf, bit drain);
        t_timer_req r;
        r.req   = req;
        r.now   = now;
        r.id    = id;
        r.tmo   = tmo;
        r.ntf   = ntf;
        r.drain = drain;
        request_backlog.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    assign no_idle = (n_taken >= 40 && n_taken < 70);

    // monitor: results first, then the transfer on the request side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (timer_results_due.size() == 0) begin
                    $error("result with nothing outstanding: kind %0h owner %0h",
                           res_ch.result_kind, res_ch.owner_id);
                    n_err++;
                end else begin
                    got_res = timer_results_due.pop_front();
                    check_field("result_kind", 32'(got_res.kind), 32'(res_ch.result_kind));
                    check_field("owner_id", 32'(got_res.owner), 32'(res_ch.owner_id));
                    check_field("wait_ms", 32'(got_res.wait_ms), 32'(res_ch.wait_ms));
                    check_field("last", 32'(got_res.last), 32'(res_ch.last));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                service_request(req_ch.req_type, req_ch.now_ms, req_ch.request_id,
                                req_ch.timeout_ms, req_ch.notify);
                req_taken = 1'b1;
                n_taken++;
            end
        end
    end

    // driver: valid holds until the transfer, a drain item waits until no results are outstanding
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if (!drv_busy || req_taken) begin
                req_taken = 1'b0;
                drv_busy  = 1'b0;
                if (request_backlog.size() != 0 &&
                        !(request_backlog[0].drain && timer_results_due.size() != 0) &&
                        (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    drv_item = request_backlog.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= drv_item.req;
                    req_ch.now_ms     <= drv_item.now;
                    req_ch.request_id <= drv_item.id;
                    req_ch.timeout_ms <= drv_item.tmo;
                    req_ch.notify     <= drv_item.ntf;
                    drv_busy = 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        int unsigned t_ms;
        int unsigned pick;
        logic [REQ_W-1:0]  r_req;
        logic [TIME_W-1:0] r_now;
        logic [ID_W-1:0]   r_id;
        logic [TMO_W-1:0]  r_tmo;
        logic [TMO_W-1:0]  tick [4];

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ADD;
        req_ch.now_ms     = '0;
        req_ch.request_id = '0;
        req_ch.timeout_ms = '0;
        req_ch.notify     = 1'b0;
        res_ch.ready      = 1'b0;

        // directed: empty cases, saturation, ties, silent expiry, full, purge
        plan_request(REQ_QUERY, 32'd0, 8'h00, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_EXPIRE, 32'd0, 8'h00, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_CANCEL, 32'd0, 8'h55, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_ADD, 32'hFFFF_FFF0, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b0);
        plan_request(REQ_QUERY, 32'd0, 8'h00, 24'd0, 1'b0, 1'b0);
        tick = '{24'd0, 24'd0, 24'd5, 24'd10};
        for (int i = 0; i < 14; i++)
            plan_request(REQ_ADD, 32'd1000, (i == 13) ? 8'd2 : 8'(i), tick[i % 4],
                         (i % 3) != 0, 1'b0);
        plan_request(REQ_ADD, 32'd1000, 8'd2, 24'd500, 1'b1, 1'b0);
        plan_request(REQ_ADD, 32'd1000, 8'hAA, 24'd1, 1'b1, 1'b0);
        plan_request(REQ_CANCEL, 32'd1000, 8'd2, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_QUERY, 32'd2000, 8'h00, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_EXPIRE, 32'd1010, 8'h00, 24'd0, 1'b0, 1'b0);
        plan_request(REQ_QUERY, 32'd1000, 8'h00, 24'd0, 1'b0, 1'b0);

        // random: mostly a steady clock with short timeouts, some wild times and ids
        t_ms = 5000;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            t_ms += $urandom_range(0, 30);
            r_now = ($urandom_range(19) == 0) ? $urandom : t_ms;
            r_id  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
            case ($urandom_range(9))
                0:       r_tmo = TMO_W'($urandom);
                1:       r_tmo = '1;
                default: r_tmo = TMO_W'($urandom_range(0, 120));
            endcase
            pick = $urandom_range(99);
            if (pick < 42)      r_req = REQ_ADD;
            else if (pick < 58) r_req = REQ_CANCEL;
            else if (pick < 75) r_req = REQ_QUERY;
            else                r_req = REQ_EXPIRE;
            plan_request(r_req, r_now, r_id, r_tmo, 1'($urandom),
                         (k == 0) || ($urandom_range(24) == 0));
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((request_backlog.size() != 0 || drv_busy || timer_results_due.size() != 0)
               && n_cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results, %0d expiries and %0d full rejections",
                 n_taken, n_results, n_expiry, n_full);
        $display("%0d field mismatches in %0d cycles", n_err, n_cycles);
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timed out with %0d results outstanding", timer_results_due.size());
            $display("FAILED: results differ");
        end else if (n_err == 0 && timer_results_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== timer_priority_queue.f =====
+incdir+rtl
rtl/tpq_pkg.sv
rtl/tpq_req_if.sv
rtl/tpq_res_if.sv
rtl/tpq_alu.sv
rtl/tpq_store.sv
rtl/tpq_ctrl.sv
rtl/timer_priority_queue.sv
tb/sv/tb.sv
